[hdl/scp_pkg.sv]
// Shared types and widths for the sphere collision push-out pipeline.
package scp_pkg;

   localparam int COORD_W = 32;
   localparam int RAD_W   = 31;
   localparam int ROOT_W  = 32;
   localparam int DSQ_W   = 66;
   localparam int NUM_W   = 65;
   localparam int QUO_W   = 33;
   localparam int AXES    = 3;

   typedef struct packed {
      logic signed [COORD_W-1:0] own_x;
      logic signed [COORD_W-1:0] own_y;
      logic signed [COORD_W-1:0] own_z;
      logic [RAD_W-1:0]          own_radius;
      logic signed [COORD_W-1:0] other_x;
      logic signed [COORD_W-1:0] other_y;
      logic signed [COORD_W-1:0] other_z;
      logic [RAD_W-1:0]          other_radius;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] new_x;
      logic signed [COORD_W-1:0] new_y;
      logic signed [COORD_W-1:0] new_z;
   } rsp_type;

   typedef struct packed {
      logic [AXES-1:0][COORD_W-1:0] own;
      logic [AXES-1:0][COORD_W-1:0] oth;
      logic [AXES-1:0][COORD_W-1:0] mag;
      logic [AXES-1:0]              neg;
      logic [COORD_W-1:0]           rsum;
      logic                         hit;
      logic                         push;
   } ctx_type;

   typedef struct packed {
      logic [DSQ_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic [ROOT_W-1:0]            den;
      logic [AXES-1:0][NUM_W-1:0]   rem;
      logic [AXES-1:0][QUO_W-1:0]   quo;
   } dv_type;

endpackage

[hdl/scp_sqrt_cell.sv]
// One root bit of the pipelined integer square root.
module scp_sqrt_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [4:0]       bit_idx,
   input  logic             in_valid,
   input  scp_pkg::ctx_type in_ctx,
   input  scp_pkg::sq_type  in_dat,
   output logic             out_valid,
   output scp_pkg::ctx_type out_ctx,
   output scp_pkg::sq_type  out_dat
);
   logic             valid_ff;
   scp_pkg::ctx_type ctx_ff;
   scp_pkg::sq_type  dat_ff, dat_in;
   logic [scp_pkg::DSQ_W-1:0] trial;

   always_comb begin
      trial = ({{(scp_pkg::DSQ_W-scp_pkg::ROOT_W){1'b0}}, in_dat.root} << ({1'b0, bit_idx} + 6'd1))
            + ({{(scp_pkg::DSQ_W-1){1'b0}}, 1'b1} << {bit_idx, 1'b0});
      dat_in = in_dat;
      if (in_dat.rem >= trial) begin
         dat_in.rem  = in_dat.rem - trial;
         dat_in.root = in_dat.root | (32'd1 << bit_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         ctx_ff <= in_ctx;
         dat_ff <= dat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctx   = ctx_ff;
   assign out_dat   = dat_ff;
endmodule

[hdl/scp_div_cell.sv]
// One quotient bit of the three-axis pipelined restoring divider.
module scp_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [5:0]       bit_idx,
   input  logic             in_valid,
   input  scp_pkg::ctx_type in_ctx,
   input  scp_pkg::dv_type  in_dat,
   output logic             out_valid,
   output scp_pkg::ctx_type out_ctx,
   output scp_pkg::dv_type  out_dat
);
   logic             valid_ff;
   scp_pkg::ctx_type ctx_ff;
   scp_pkg::dv_type  dat_ff, dat_in;
   logic [scp_pkg::NUM_W-1:0] trial;

   always_comb begin
      trial  = {{(scp_pkg::NUM_W-scp_pkg::ROOT_W){1'b0}}, in_dat.den} << bit_idx;
      dat_in = in_dat;
      for (int a = 0; a < scp_pkg::AXES; a++) begin
         if (in_dat.rem[a] >= trial) begin
            dat_in.rem[a] = in_dat.rem[a] - trial;
            dat_in.quo[a] = in_dat.quo[a] | ({{(scp_pkg::QUO_W-1){1'b0}}, 1'b1} << bit_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         ctx_ff <= in_ctx;
         dat_ff <= dat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctx   = ctx_ff;
   assign out_dat   = dat_ff;
endmodule

[hdl/sphere_collision_push_out.sv]
// Sphere collision push-out: top level pipeline.
// Stages from accepted req word to rsp word: 3 setup, 32 root cells,
// 2 product/round, 33 quotient cells, 1 saturate, 1 output register.
// Throughput: one word per cycle; the pipeline holds while rsp is stalled.
// Reset clears stage valid bits only; no other state.
module sphere_collision_push_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  scp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output scp_pkg::rsp_type rsp_data
);
   localparam int RB = scp_pkg::ROOT_W;
   localparam int QB = scp_pkg::QUO_W;

   logic en;
   logic rsp_valid_ff;
   scp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // stage 1: differences
   logic [2:0][31:0] in_own, in_oth;
   logic [2:0][32:0] dif, mg;
   scp_pkg::ctx_type c1_in, c1_ff;
   logic far_in, far1_ff, v1_ff;

   always_comb begin
      in_own = {req_data.own_x, req_data.own_y, req_data.own_z};
      in_oth = {req_data.other_x, req_data.other_y, req_data.other_z};
      far_in = 1'b0;
      c1_in  = '0;
      for (int a = 0; a < 3; a++) begin
         dif[a] = {in_own[a][31], in_own[a]} - {in_oth[a][31], in_oth[a]};
         mg[a]  = dif[a][32] ? -dif[a] : dif[a];
         if (mg[a][32]) far_in = 1'b1;
         c1_in.own[a] = in_own[a];
         c1_in.oth[a] = in_oth[a];
         c1_in.mag[a] = mg[a][31:0];
         c1_in.neg[a] = dif[a][32];
      end
      c1_in.rsum = {1'b0, req_data.own_radius} + {1'b0, req_data.other_radius};
   end

   // stage 2: squares
   scp_pkg::ctx_type c2_ff;
   logic far2_ff, v2_ff;
   logic [2:0][63:0] sq_ff;
   logic [63:0] rsq_ff;

   // stage 3: compare
   scp_pkg::ctx_type c3_ff, c3_in;
   logic v3_ff;
   logic [65:0] dsq_ff, dsq_in;

   always_comb begin
      dsq_in = {2'b0, sq_ff[0]} + {2'b0, sq_ff[1]} + {2'b0, sq_ff[2]};
      c3_in  = c2_ff;
      c3_in.hit  = !far2_ff && (dsq_in <= {2'b0, rsq_ff});
      c3_in.push = c3_in.hit && (dsq_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         c1_ff   <= c1_in;
         far1_ff <= far_in;
         c2_ff   <= c1_ff;
         far2_ff <= far1_ff;
         for (int a = 0; a < 3; a++) sq_ff[a] <= c1_ff.mag[a] * c1_ff.mag[a];
         rsq_ff  <= c1_ff.rsum * c1_ff.rsum;
         c3_ff   <= c3_in;
         dsq_ff  <= dsq_in;
      end
   end

   // square root chain
   logic             sv [0:RB];
   scp_pkg::ctx_type sc [0:RB];
   scp_pkg::sq_type  sd [0:RB];

   assign sv[0] = v3_ff;
   assign sc[0] = c3_ff;
   assign sd[0] = '{rem: dsq_ff, root: '0};

   for (genvar i = 0; i < RB; i++) begin : g_sqrt
      scp_sqrt_cell u_cell (
         .clock, .reset, .en,
         .bit_idx   (5'(RB - 1 - i)),
         .in_valid  (sv[i]),   .in_ctx  (sc[i]),   .in_dat  (sd[i]),
         .out_valid (sv[i+1]), .out_ctx (sc[i+1]), .out_dat (sd[i+1])
      );
   end

   // products and rounding
   logic vm_ff, va_ff;
   scp_pkg::ctx_type cm_ff, ca_ff;
   logic [31:0] lm_ff, la_ff;
   logic [2:0][63:0] pr_ff;
   logic [2:0][64:0] nu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
         va_ff <= 1'b0;
      end else if (en) begin
         vm_ff <= sv[RB];
         va_ff <= vm_ff;
      end
      if (en) begin
         cm_ff <= sc[RB];
         lm_ff <= sd[RB].root;
         for (int a = 0; a < 3; a++) pr_ff[a] <= sc[RB].mag[a] * sc[RB].rsum;
         ca_ff <= cm_ff;
         la_ff <= lm_ff;
         for (int a = 0; a < 3; a++)
            nu_ff[a] <= {1'b0, pr_ff[a]} + {34'b0, lm_ff[31:1]};
      end
   end

   // division chain
   logic             dv [0:QB];
   scp_pkg::ctx_type dc [0:QB];
   scp_pkg::dv_type  dd [0:QB];

   assign dv[0] = va_ff;
   assign dc[0] = ca_ff;
   assign dd[0] = '{den: la_ff, rem: nu_ff, quo: '0};

   for (genvar i = 0; i < QB; i++) begin : g_div
      scp_div_cell u_cell (
         .clock, .reset, .en,
         .bit_idx   (6'(QB - 1 - i)),
         .in_valid  (dv[i]),   .in_ctx  (dc[i]),   .in_dat  (dd[i]),
         .out_valid (dv[i+1]), .out_ctx (dc[i+1]), .out_dat (dd[i+1])
      );
   end

   // saturate and output
   logic vs_ff;
   scp_pkg::ctx_type cs_ff;
   logic [2:0][34:0] sm_ff;
   logic [2:0][34:0] sm_in;
   logic [2:0][33:0] off;
   logic [2:0][31:0] res;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         off[a]   = dc[QB].neg[a] ? -{1'b0, dd[QB].quo[a]} : {1'b0, dd[QB].quo[a]};
         sm_in[a] = {{3{dc[QB].oth[a][31]}}, dc[QB].oth[a]} + {off[a][33], off[a]};
      end
      for (int a = 0; a < 3; a++) begin
         if (!cs_ff.push)
            res[a] = cs_ff.own[a];
         else if (!sm_ff[a][34] && (sm_ff[a][33:31] != 3'b000))
            res[a] = 32'h7FFF_FFFF;
         else if (sm_ff[a][34] && (sm_ff[a][33:31] != 3'b111))
            res[a] = 32'h8000_0000;
         else
            res[a] = sm_ff[a][31:0];
      end
      // axis 2 is x, axis 0 is z
      rsp_data_in.hit   = cs_ff.hit;
      rsp_data_in.new_x = res[2];
      rsp_data_in.new_y = res[1];
      rsp_data_in.new_z = res[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vs_ff        <= dv[QB];
         rsp_valid_ff <= vs_ff;
      end
      if (en) begin
         cs_ff       <= dc[QB];
         sm_ff       <= sm_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
